// ===== rtl/s256c_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s256c_pkg;

  localparam int WordW  = 32;
  localparam int NumCv  = 8;
  localparam int NumMsg = 16;
  localparam int NumRnd = 64;

  typedef logic [WordW-1:0] word_t;

  // sequencer -> datapath controls
  typedef struct packed {
    logic push;    // take a new message word into the window
    logic load;    // copy chaining value into working variables
    logic step;    // one compression round / one schedule shift
    logic rotate;  // shift working variables out, a first
  } ctrl_t;

  localparam word_t RoundK [NumRnd] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/s256c_sched.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 16-word sliding message schedule window; win_q[0] is the current W[t].
module s256c_sched (
  input  wire logic             clk_i,
  input  wire s256c_pkg::ctrl_t ctrl_i,
  input  wire s256c_pkg::word_t data_i,
  output s256c_pkg::word_t      w_o
);

  s256c_pkg::word_t win_q [s256c_pkg::NumMsg];
  s256c_pkg::word_t win_d [s256c_pkg::NumMsg];
  s256c_pkg::word_t w_next;

  assign w_next = s256c_pkg::ssig1(win_q[14]) + win_q[9]
                + s256c_pkg::ssig0(win_q[1]) + win_q[0];

  always_comb begin
    for (int i = 0; i < s256c_pkg::NumMsg; i++) win_d[i] = win_q[i];
    if (ctrl_i.push || ctrl_i.step) begin
      for (int i = 0; i < s256c_pkg::NumMsg - 1; i++) win_d[i] = win_q[i+1];
      win_d[s256c_pkg::NumMsg-1] = ctrl_i.push ? data_i : w_next;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < s256c_pkg::NumMsg; i++) win_q[i] <= win_d[i];
  end

  assign w_o = win_q[0];

endmodule

`default_nettype wire

// ===== rtl/s256c_round.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Working variables a..h and the shared round unit.
module s256c_round (
  input  wire logic                                   clk_i,
  input  wire s256c_pkg::ctrl_t                       ctrl_i,
  input  wire logic [s256c_pkg::NumCv-1:0][s256c_pkg::WordW-1:0] cv_i,
  input  wire s256c_pkg::word_t                       k_i,
  input  wire s256c_pkg::word_t                       w_i,
  output s256c_pkg::word_t                            head_o
);

  s256c_pkg::word_t v_q [s256c_pkg::NumCv];
  s256c_pkg::word_t v_d [s256c_pkg::NumCv];
  s256c_pkg::word_t t1, t2, ch, maj;

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + s256c_pkg::bsig1(v_q[4]) + ch + k_i + w_i;
  assign t2  = s256c_pkg::bsig0(v_q[0]) + maj;

  always_comb begin
    for (int i = 0; i < s256c_pkg::NumCv; i++) v_d[i] = v_q[i];
    if (ctrl_i.load) begin
      for (int i = 0; i < s256c_pkg::NumCv; i++) v_d[i] = cv_i[i];
    end else if (ctrl_i.step) begin
      for (int i = 1; i < s256c_pkg::NumCv; i++) v_d[i] = v_q[i-1];
      v_d[4] = v_q[3] + t1;
      v_d[0] = t1 + t2;
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < s256c_pkg::NumCv - 1; i++) v_d[i] = v_q[i+1];
      v_d[s256c_pkg::NumCv-1] = v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < s256c_pkg::NumCv; i++) v_q[i] <= v_d[i];
  end

  assign head_o = v_q[0];

endmodule

`default_nettype wire

// ===== rtl/sha256_block_compress.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Load and non-final message words are each taken while busy stays low.
// The sixteenth message word starts the 64 rounds (one round per cycle on the
// shared round unit) and the output phase: busy is high through both, and the
// digest words strobe on done_o after the rounds, one per cycle, no stall.
// Reset is asynchronous active low and clears the chaining value, the word
// count and the sequencer.
module sha256_block_compress (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind_i,
  input  wire logic [2:0]  word_index_i,
  input  wire logic [31:0] data_word_i,
  output logic             done_o,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       digest_index_o,
  output logic             last_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StOut   = 2'd2;

  logic [1:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [3:0] words_q, words_d;
  logic [s256c_pkg::NumCv-1:0][s256c_pkg::WordW-1:0] cv_q, cv_d;
  logic             done_q, done_d;
  logic             last_q, last_d;
  logic [2:0]       idx_q, idx_d;
  s256c_pkg::word_t dig_q, dig_d;
  s256c_pkg::word_t w_cur, head, sum;
  s256c_pkg::ctrl_t ctrl;
  logic             accept;

  assign accept = start && !busy;
  assign sum    = cv_q[0] + head;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    words_d     = words_q;
    cv_d        = cv_q;
    done_d      = 1'b0;
    last_d      = 1'b0;
    idx_d       = idx_q;
    dig_d       = dig_q;
    ctrl        = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (!kind_i) begin
            cv_d[word_index_i] = data_word_i;
            words_d            = '0;
          end else begin
            ctrl.push = 1'b1;
            words_d   = words_q + 4'd1;
            if (words_q == 4'd15) begin
              ctrl.load = 1'b1;
              cnt_d     = '0;
              state_d   = StRound;
            end
          end
        end
      end
      StRound: begin
        ctrl.step = 1'b1;
        cnt_d     = cnt_q + 6'd1;
        if (cnt_q == 6'(s256c_pkg::NumRnd - 1)) begin
          cnt_d   = '0;
          state_d = StOut;
        end
      end
      StOut: begin
        // chaining value and working vars rotate together, word 0 at the head
        ctrl.rotate = 1'b1;
        for (int i = 0; i < s256c_pkg::NumCv - 1; i++) cv_d[i] = cv_q[i+1];
        cv_d[s256c_pkg::NumCv-1] = sum;
        dig_d  = sum;
        idx_d  = cnt_q[2:0];
        done_d = 1'b1;
        last_d = (cnt_q[2:0] == 3'd7);
        cnt_d  = cnt_q + 6'd1;
        if (cnt_q[2:0] == 3'd7) begin
          cnt_d   = '0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      words_q <= '0;
      cv_q    <= '0;
      done_q  <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      words_q <= words_d;
      cv_q    <= cv_d;
      done_q  <= done_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    dig_q <= dig_d;
  end

  s256c_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .data_i (data_word_i),
    .w_o    (w_cur)
  );

  s256c_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .cv_i   (cv_q),
    .k_i    (s256c_pkg::RoundK[cnt_q]),
    .w_i    (w_cur),
    .head_o (head)
  );

  assign busy           = (state_q != StIdle);
  assign done_o         = done_q;
  assign digest_word_o  = dig_q;
  assign digest_index_o = idx_q;
  assign last_o         = last_q;

  a_block_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && kind_i && words_q == 4'd15 |=> state_q == StRound && cnt_q == 6'd0)
    else $error("sixteenth word did not start the rounds");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> done_o && digest_index_o == 3'd7)
    else $error("last flag off the final word");

  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && digest_index_o != 3'd0 |->
      $past(done_o) && digest_index_o == $past(digest_index_o) + 3'd1)
    else $error("digest words out of order");

  a_no_out_while_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StRound |-> !done_o)
    else $error("digest word during rounds");

endmodule

`default_nettype wire
